/* src/snvu_pkg.sv */
// Package: shared types, codes and a saturation helper for the velocity update block.
package snvu_pkg;

    localparam int VAL_W      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIVIDEND_W = 47;   // dt << 15
    localparam int DT_SHIFT   = 15;

    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_TIME_STEP  = 1'b1;

    localparam logic [10:0] ROW_LENGTH_RESET = 11'd1024;
    localparam logic [31:0] TIME_STEP_RESET  = 32'd655;

    typedef struct packed {
        logic [31:0]        mass;
        logic signed [31:0] pres;
        logic signed [31:0] visc;
        logic [31:0]        xarea;
    } t_line_word;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MASS, ST_SUM, ST_X1, ST_X2, ST_Y1, ST_Y2,
        ST_DIV, ST_VX, ST_VY, ST_VFIN, ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        MUL_MASS, MUL_X1, MUL_X2, MUL_Y1, MUL_Y2, MUL_VX, MUL_VY
    } t_mul_sel;

    typedef struct packed {
        logic     in_ready;
        logic     line_we;
        logic     div_start;
        t_mul_sel mul_sel;
    } t_ctrl;

    function automatic logic signed [31:0] f_sat_s32(input logic signed [50:0] x);
        logic signed [31:0] r;
        if (x > 51'sh7FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (x < -51'sh80000000)
            r = -32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

/* src/stencil_node_velocity_update_top.sv */
// Top level: streaming nodal velocity update with a previous-row line store.
//
//  channel | direction | handshake              | words
//  --------+-----------+------------------------+-------------------------------
//  cell in | input     | i_in_valid / o_in_stall | density .. y_velocity_old
//  node out| output    | o_out_valid / i_out_stall| velocities, column, row, flag
//  config  | input     | i_cfg_we (no wait)      | row_length, time_step
//
// One word at a time. A border cell passes read, mass and store; a
// zero-mass node adds a finish step; any other node waits on the 47-step
// restoring divider for dt/2M, which runs while the shared 33x33
// multiplier works out the four force terms.
// Synchronous active-low reset clears counters, left neighbours and
// config; the line store needs no clearing. A stalled result waits in the
// output register; the next cell is taken meanwhile until its own result.
module stencil_node_velocity_update_top #(
    parameter int MAX_ROW_LENGTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_density,
    input  logic [31:0]        i_volume,
    input  logic signed [31:0] i_pressure,
    input  logic signed [31:0] i_viscosity,
    input  logic [31:0]        i_x_face_area,
    input  logic [31:0]        i_y_face_area,
    input  logic signed [31:0] i_x_velocity_old,
    input  logic signed [31:0] i_y_velocity_old,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_x_velocity_new,
    output logic signed [31:0] o_y_velocity_new,
    output logic [9:0]         o_node_column,
    output logic [15:0]        o_node_row,
    output logic               o_zero_mass
);

    localparam int CW = (MAX_ROW_LENGTH > 2) ? $clog2(MAX_ROW_LENGTH) : 1;

    snvu_pkg::t_state r_state, n_state;
    snvu_pkg::t_ctrl  ctrl;

    // configuration
    logic [10:0] r_row_length;
    logic [31:0] r_time_step;

    // position
    logic [CW-1:0] r_col, r_idx;
    logic [15:0]   r_row, r_nrow;

    // captured cell
    logic [31:0]        r_dens, r_vol, r_xa, r_ya;
    logic signed [31:0] r_p, r_q, r_vx_old, r_vy_old;

    // neighbours
    snvu_pkg::t_line_word up_word, r_up;
    logic [31:0]        r_lc_mass, r_lc_yarea, r_lp_mass;
    logic signed [31:0] r_lc_pres, r_lc_visc, r_lp_pres, r_lp_visc;

    // arithmetic
    logic [31:0]        r_m, r_nodal, r_s, r_ax2, r_ay2, quotient;
    logic signed [31:0] r_dx1, r_dx2, r_dy1, r_dy2, r_fx, r_fy, r_vx, r_vy;
    logic signed [49:0] r_fa, r_fb, r_px;
    logic               r_zero, div_busy;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [49:0] prod_q;

    // output register
    logic               r_out_valid, r_zero_o;
    logic signed [31:0] r_xo, r_yo;
    logic [9:0]         r_col_o;
    logic [15:0]        r_row_o;

    logic        in_acc, produced, out_free;
    logic [31:0] len_eff, col_next;
    logic [33:0] mass_sum;
    logic signed [32:0] w, wl, wu, wd;

    assign in_acc   = i_in_valid && ctrl.in_ready;
    assign out_free = !r_out_valid || !i_out_stall;
    assign produced = (r_idx != '0) && (r_nrow != 16'd0);

    // row-end test with the row length clamped to its legal range
    always_comb begin
        len_eff = 32'(r_row_length);
        if (len_eff < 32'd2)
            len_eff = 32'd2;
        if (len_eff > 32'(MAX_ROW_LENGTH))
            len_eff = 32'(MAX_ROW_LENGTH);
        col_next = 32'(r_col) + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= snvu_pkg::ROW_LENGTH_RESET;
            r_time_step  <= snvu_pkg::TIME_STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                snvu_pkg::REG_ROW_LENGTH: r_row_length <= i_cfg_data[10:0];
                snvu_pkg::REG_TIME_STEP:  r_time_step  <= i_cfg_data;
                default:                  r_time_step  <= r_time_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_next >= len_eff) begin
                r_col <= '0;
                r_row <= r_row + 16'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            snvu_pkg::ST_IDLE: if (i_in_valid) n_state = snvu_pkg::ST_MASS;
            snvu_pkg::ST_MASS: n_state = snvu_pkg::ST_SUM;
            snvu_pkg::ST_SUM: begin
                if (!produced)
                    n_state = snvu_pkg::ST_IDLE;
                else if (mass_sum[33:2] == 32'd0)
                    n_state = snvu_pkg::ST_FIN;
                else
                    n_state = snvu_pkg::ST_X1;
            end
            snvu_pkg::ST_X1:   n_state = snvu_pkg::ST_X2;
            snvu_pkg::ST_X2:   n_state = snvu_pkg::ST_Y1;
            snvu_pkg::ST_Y1:   n_state = snvu_pkg::ST_Y2;
            snvu_pkg::ST_Y2:   n_state = snvu_pkg::ST_DIV;
            snvu_pkg::ST_DIV:  if (!div_busy) n_state = snvu_pkg::ST_VX;
            snvu_pkg::ST_VX:   n_state = snvu_pkg::ST_VY;
            snvu_pkg::ST_VY:   n_state = snvu_pkg::ST_VFIN;
            snvu_pkg::ST_VFIN: n_state = snvu_pkg::ST_FIN;
            snvu_pkg::ST_FIN:  if (out_free) n_state = snvu_pkg::ST_IDLE;
            default:           n_state = snvu_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl = '{in_ready: 1'b0, line_we: 1'b0, div_start: 1'b0,
                 mul_sel: snvu_pkg::MUL_MASS};
        unique case (r_state)
            snvu_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
            snvu_pkg::ST_SUM: begin
                ctrl.line_we   = 1'b1;
                ctrl.div_start = produced && (mass_sum[33:2] != 32'd0);
            end
            snvu_pkg::ST_X1: ctrl.mul_sel = snvu_pkg::MUL_X1;
            snvu_pkg::ST_X2: ctrl.mul_sel = snvu_pkg::MUL_X2;
            snvu_pkg::ST_Y1: ctrl.mul_sel = snvu_pkg::MUL_Y1;
            snvu_pkg::ST_Y2: ctrl.mul_sel = snvu_pkg::MUL_Y2;
            snvu_pkg::ST_VX: ctrl.mul_sel = snvu_pkg::MUL_VX;
            snvu_pkg::ST_VY: ctrl.mul_sel = snvu_pkg::MUL_VY;
            default:         ctrl.mul_sel = snvu_pkg::MUL_MASS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= snvu_pkg::ST_IDLE;
        else
            r_state <= n_state;
    end

    assign o_in_stall = !ctrl.in_ready;

    // shared multiplier
    always_comb begin
        unique case (ctrl.mul_sel)
            snvu_pkg::MUL_MASS: begin mul_a = {1'b0, r_dens}; mul_b = {1'b0, r_vol}; end
            snvu_pkg::MUL_X1:   begin mul_a = {1'b0, r_xa};   mul_b = 33'(r_dx1); end
            snvu_pkg::MUL_X2:   begin mul_a = {1'b0, r_ax2};  mul_b = 33'(r_dx2); end
            snvu_pkg::MUL_Y1:   begin mul_a = {1'b0, r_ya};   mul_b = 33'(r_dy1); end
            snvu_pkg::MUL_Y2:   begin mul_a = {1'b0, r_ay2};  mul_b = 33'(r_dy2); end
            snvu_pkg::MUL_VX:   begin mul_a = {1'b0, r_s};    mul_b = 33'(r_fx);  end
            snvu_pkg::MUL_VY:   begin mul_a = {1'b0, r_s};    mul_b = 33'(r_fy);  end
            default:            begin mul_a = '0;             mul_b = '0;         end
        endcase
    end
    assign prod   = 66'(mul_a) * 66'(mul_b);
    assign prod_q = prod[65:16];   // arithmetic shift = floor

    // pressure plus viscosity sums and the four-cell mass sum behind the nodal mass
    assign w        = 33'(r_p) + 33'(r_q);
    assign wl       = 33'(r_lc_pres) + 33'(r_lc_visc);
    assign wu       = 33'(r_up.pres) + 33'(r_up.visc);
    assign wd       = 33'(r_lp_pres) + 33'(r_lp_visc);
    assign mass_sum = 34'(r_m) + 34'(r_up.mass) + 34'(r_lc_mass) + 34'(r_lp_mass);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dens   <= i_density;
            r_vol    <= i_volume;
            r_p      <= i_pressure;
            r_q      <= i_viscosity;
            r_xa     <= i_x_face_area;
            r_ya     <= i_y_face_area;
            r_vx_old <= i_x_velocity_old;
            r_vy_old <= i_y_velocity_old;
            r_idx    <= r_col;
            r_nrow   <= r_row;
        end
        unique case (r_state)
            snvu_pkg::ST_MASS: begin
                r_m  <= (|prod[63:48]) ? 32'hFFFFFFFF : prod[47:16];
                r_up <= up_word;
            end
            snvu_pkg::ST_SUM: begin
                r_nodal <= mass_sum[33:2];
                r_dx1   <= snvu_pkg::f_sat_s32(51'(34'(w) - 34'(wl)));
                r_dx2   <= snvu_pkg::f_sat_s32(51'(34'(wu) - 34'(wd)));
                r_dy1   <= snvu_pkg::f_sat_s32(51'(34'(w) - 34'(wu)));
                r_dy2   <= snvu_pkg::f_sat_s32(51'(34'(wl) - 34'(wd)));
                r_ax2   <= r_up.xarea;
                r_ay2   <= r_lc_yarea;
                r_vx    <= r_vx_old;
                r_vy    <= r_vy_old;
                r_zero  <= (mass_sum[33:2] == 32'd0);
            end
            snvu_pkg::ST_X1: r_fa <= prod_q;
            snvu_pkg::ST_X2: r_fb <= prod_q;
            snvu_pkg::ST_Y1: begin
                r_fx <= snvu_pkg::f_sat_s32(51'(r_fa) + 51'(r_fb));
                r_fa <= prod_q;
            end
            snvu_pkg::ST_Y2: r_fb <= prod_q;
            snvu_pkg::ST_DIV: begin
                r_fy <= snvu_pkg::f_sat_s32(51'(r_fa) + 51'(r_fb));
                r_s  <= quotient;
            end
            snvu_pkg::ST_VX: r_px <= prod_q;
            snvu_pkg::ST_VY: begin
                r_vx <= snvu_pkg::f_sat_s32(51'(r_vx_old) - 51'(r_px));
                r_px <= prod_q;
            end
            snvu_pkg::ST_VFIN: r_vy <= snvu_pkg::f_sat_s32(51'(r_vy_old) - 51'(r_px));
            default: r_px <= r_px;
        endcase
    end

    // left neighbours move on once the cell is stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc_mass  <= '0;
            r_lc_pres  <= '0;
            r_lc_visc  <= '0;
            r_lc_yarea <= '0;
            r_lp_mass  <= '0;
            r_lp_pres  <= '0;
            r_lp_visc  <= '0;
        end else if (ctrl.line_we) begin
            r_lc_mass  <= r_m;
            r_lc_pres  <= r_p;
            r_lc_visc  <= r_q;
            r_lc_yarea <= r_ya;
            r_lp_mass  <= r_up.mass;
            r_lp_pres  <= r_up.pres;
            r_lp_visc  <= r_up.visc;
        end
    end

    snvu_line_store #(
        .DEPTH (MAX_ROW_LENGTH),
        .AW    (CW)
    ) u_line (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (up_word),
        .i_wr_en   (ctrl.line_we),
        .i_wr_addr (r_idx),
        .i_wr_data ('{mass: r_m, pres: r_p, visc: r_q, xarea: r_xa})
    );

    snvu_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.div_start),
        .i_dividend ({r_time_step, {snvu_pkg::DT_SHIFT{1'b0}}}),
        .i_divisor  (r_nodal),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == snvu_pkg::ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == snvu_pkg::ST_FIN && out_free) begin
            r_xo     <= r_vx;
            r_yo     <= r_vy;
            r_col_o  <= 10'(r_idx);
            r_row_o  <= r_nrow;
            r_zero_o <= r_zero;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_x_velocity_new = r_xo;
    assign o_y_velocity_new = r_yo;
    assign o_node_column    = r_col_o;
    assign o_node_row       = r_row_o;
    assign o_zero_mass      = r_zero_o;

endmodule

/* src/snvu_line_store.sv */
// Previous-row line store: one wide synchronous memory with a registered read.
module snvu_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output snvu_pkg::t_line_word o_rd_data,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  snvu_pkg::t_line_word i_wr_data
);

    snvu_pkg::t_line_word r_mem [DEPTH];
    snvu_pkg::t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/snvu_divider.sv */
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
module snvu_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [snvu_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quotient
);

    localparam int DW = snvu_pkg::DIVIDEND_W;

    logic          r_busy;
    logic [5:0]    r_cnt;
    logic [32:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [32:0]   shifted;
    logic [33:0]   diff;
    logic          ge;

    assign shifted = {r_rem[31:0], r_quo[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, i_divisor};
    assign ge      = ~diff[33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[32:0] : shifted;
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = (|r_quo[DW-1:32]) ? 32'hFFFFFFFF : r_quo[31:0];

endmodule

/* src/snvu_checker.sv */
// Port-level checker for the velocity update block, bound to the top level.
module snvu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_x_velocity_new,
    input logic [9:0]  o_node_column,
    input logic [15:0] o_node_row
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_x_velocity_new))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while first in work");

    a_no_border_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_node_column != 10'd0 && o_node_row != 16'd0)
        else $error("result for a border cell");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present after reset");

endmodule

bind stencil_node_velocity_update_top snvu_checker u_snvu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_x_velocity_new (o_x_velocity_new),
    .o_node_column    (o_node_column),
    .o_node_row       (o_node_row)
);

/* bench/stencil_node_velocity_update_top_tb.sv */
// Testbench for the streaming nodal velocity update block: directed table and random phases.
`timescale 1ns / 1ps

module stencil_node_velocity_update_top_tb;

    localparam int LINE_DEPTH = 1024;
    localparam int FILL_CELLS = 160;
    localparam int DRAIN_CYCLES = 70;   // longer than one node's divider pass

    typedef struct {
        logic [31:0]        density, volume;
        logic signed [31:0] pressure, viscosity;
        logic [31:0]        xarea, yarea;
        logic signed [31:0] vx, vy;
    } t_cell;

    typedef struct {
        logic signed [31:0] vx, vy;
        logic [9:0]         col;
        logic [15:0]        row;
        logic               zero;
    } t_node;

    // directed row: a cell and, where obvious, the velocities and flag it must give
    typedef struct {
        t_cell              c;
        bit                 typed;
        logic signed [31:0] vx, vy;
        logic               zero;
    } t_dir_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = snvu_pkg::REG_ROW_LENGTH;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    t_cell              in_word = '{default: '0};
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_node              out_word;

    int  send_gap_pct = 0;
    int  stall_pct = 0;
    bit  failed = 1'b0;
    t_node node_q[$];

    // node model state
    longint      line_mass[LINE_DEPTH];
    longint      line_pres[LINE_DEPTH];
    longint      line_visc[LINE_DEPTH];
    longint      line_xarea[LINE_DEPTH];
    longint      lc_mass, lc_pres, lc_visc, lc_yarea;
    longint      lp_mass, lp_pres, lp_visc;
    int          col_cnt, row_cnt;
    logic [10:0] row_len_reg;
    logic [31:0] dt_reg;

    t_dir_row dir_tab[16];

    initial begin
        forever #6 clk = ~clk;
    end

    stencil_node_velocity_update_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_density       (in_word.density),
        .i_volume        (in_word.volume),
        .i_pressure      (in_word.pressure),
        .i_viscosity     (in_word.viscosity),
        .i_x_face_area   (in_word.xarea),
        .i_y_face_area   (in_word.yarea),
        .i_x_velocity_old(in_word.vx),
        .i_y_velocity_old(in_word.vy),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_x_velocity_new(out_word.vx),
        .o_y_velocity_new(out_word.vy),
        .o_node_column   (out_word.col),
        .o_node_row      (out_word.row),
        .o_zero_mass     (out_word.zero)
    );

    function automatic longint clamp_s32(input longint x);
        if (x > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
        if (x < -64'sh80000000) return -64'sh80000000;
        return x;
    endfunction

    // arithmetic shift of a Q32.32 product is floor to Q16.16
    function automatic longint area_force(input longint a1, input longint d1,
                                          input longint a2, input longint d2);
        return clamp_s32(((a1 * clamp_s32(d1)) >>> 16) + ((a2 * clamp_s32(d2)) >>> 16));
    endfunction

    task automatic accel_node(input t_cell c, output bit has, output t_node r);
        logic [63:0] mprod, sum, nodal, quot;
        longint      m, p, q, xa, ya, s, w, wl, wu, wd, fx, fy;
        longint      up_m, up_p, up_q, up_xa, len;
        int          idx;
        idx   = col_cnt % LINE_DEPTH;
        mprod = {32'b0, c.density} * {32'b0, c.volume};
        m     = ((mprod >> 16) > 64'hFFFFFFFF) ? 64'hFFFFFFFF : longint'(mprod >> 16);
        p     = c.pressure;
        q     = c.viscosity;
        xa    = {32'b0, c.xarea};
        ya    = {32'b0, c.yarea};
        up_m  = line_mass[idx];
        up_p  = line_pres[idx];
        up_q  = line_visc[idx];
        up_xa = line_xarea[idx];
        has   = (col_cnt != 0) && (row_cnt != 0);
        r.vx  = c.vx;
        r.vy  = c.vy;
        r.col = col_cnt[9:0];
        r.row = row_cnt[15:0];
        r.zero = 1'b1;
        if (has) begin
            sum   = m + up_m + lc_mass + lp_mass;
            nodal = sum >> 2;
            if (nodal != 0) begin
                quot = ({32'b0, dt_reg} << 15) / nodal;
                s    = (quot > 64'hFFFFFFFF) ? 64'hFFFFFFFF : longint'(quot);
                w    = p + q;
                wl   = lc_pres + lc_visc;
                wu   = up_p + up_q;
                wd   = lp_pres + lp_visc;
                fx   = area_force(xa, w - wl, up_xa, wu - wd);
                fy   = area_force(ya, w - wu, lc_yarea, wl - wd);
                r.vx = clamp_s32(longint'(c.vx) - ((s * fx) >>> 16));
                r.vy = clamp_s32(longint'(c.vy) - ((s * fy) >>> 16));
                r.zero = 1'b0;
            end
        end
        lp_mass = up_m;
        lp_pres = up_p;
        lp_visc = up_q;
        line_mass[idx]  = m;
        line_pres[idx]  = p;
        line_visc[idx]  = q;
        line_xarea[idx] = xa;
        lc_mass  = m;
        lc_pres  = p;
        lc_visc  = q;
        lc_yarea = ya;
        len = row_len_reg;
        if (len < 2) len = 2;
        if (len > LINE_DEPTH) len = LINE_DEPTH;
        if (col_cnt + 1 >= len) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1) & 16'hFFFF;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    // one word in; returns once accepted and the model has moved on
    task automatic send_cell(input t_cell c, output bit has, output t_node r);
        if ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= c;
        do @(posedge clk); while (in_stall);
        accel_node(c, has, r);
    endtask

    task automatic push_cell(input t_cell c);
        bit    has;
        t_node r;
        send_cell(c, has, r);
        if (has) node_q.push_back(r);
    endtask

    // sender holds off until every node is out, then the block settles
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (node_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == snvu_pkg::REG_ROW_LENGTH) row_len_reg = data[10:0];
        else dt_reg = data;
    endtask

    // corner values turn up often
    function automatic logic [31:0] edgy_word();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return 32'h80000000;
            3: return 32'h7FFFFFFF;
            4: return $urandom_range(32'h3FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cell rand_cell();
        t_cell c;
        c.density   = ($urandom_range(4) == 0) ? 32'h0 :
                      ($urandom_range(9) == 0) ? edgy_word() : $urandom_range(32'h3FFFF);
        c.volume    = ($urandom_range(9) == 0) ? edgy_word() : $urandom_range(32'h3FFFF);
        c.pressure  = edgy_word();
        c.viscosity = edgy_word();
        c.xarea     = edgy_word();
        c.yarea     = edgy_word();
        c.vx        = edgy_word();
        c.vy        = edgy_word();
        return c;
    endfunction

    task automatic random_phase(input logic [31:0] len, input logic [31:0] dt,
                                input int gap, input int stall, input int count);
        write_reg(snvu_pkg::REG_ROW_LENGTH, len);
        write_reg(snvu_pkg::REG_TIME_STEP, dt);
        send_gap_pct = gap;
        stall_pct    = stall;
        repeat (count) push_cell(rand_cell());
        drain();
    endtask

    // receiver: random stall and checking of each node word against the oldest expectation
    always @(posedge clk) begin
        t_node e;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            if (node_q.size() == 0) begin
                $error("node word with nothing expected: col %0d row %0d",
                       out_word.col, out_word.row);
                failed = 1'b1;
            end else begin
                e = node_q.pop_front();
                if (out_word.vx !== e.vx) begin
                    $error("x_velocity_new: expected %0d, got %0d", e.vx, out_word.vx);
                    failed = 1'b1;
                end
                if (out_word.vy !== e.vy) begin
                    $error("y_velocity_new: expected %0d, got %0d", e.vy, out_word.vy);
                    failed = 1'b1;
                end
                if (out_word.col !== e.col) begin
                    $error("node_column: expected %0d, got %0d", e.col, out_word.col);
                    failed = 1'b1;
                end
                if (out_word.row !== e.row) begin
                    $error("node_row: expected %0d, got %0d", e.row, out_word.row);
                    failed = 1'b1;
                end
                if (out_word.zero !== e.zero) begin
                    $error("zero_mass: expected %0d, got %0d", e.zero, out_word.zero);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        bit    has;
        t_node r;

        // directed table, walked from col 0 row 1 with row length 2
        dir_tab[0]  = '{'{32'h0, 32'h0, 32'sh0, 32'sh0, 32'h0, 32'h0, 32'sh0, 32'sh0},
                        0, 0, 0, 0};
        dir_tab[1]  = '{'{32'h0, 32'hFFFFFFFF, 32'sh10000, -32'sh10000, 32'h10000,
                          32'h10000, 32'sh100, -32'sh100}, 0, 0, 0, 0};
        dir_tab[2]  = '{'{32'hFFFFFFFF, 32'h0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'hFFFFFFFF,
                          32'hFFFFFFFF, 32'sh0, 32'sh0}, 0, 0, 0, 0};
        // four massless cells around the node: old velocities pass through
        dir_tab[3]  = '{'{32'h0, 32'h12345, -32'sh80000000, -32'sh80000000, 32'hFFFFFFFF,
                          32'hFFFFFFFF, -32'sh80000000, 32'sh7FFFFFFF},
                        1, -32'sh80000000, 32'sh7FFFFFFF, 1'b1};
        dir_tab[4]  = '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                          32'hFFFFFFFF, 32'hFFFFFFFF, 32'sh7FFFFFFF, -32'sh80000000},
                        0, 0, 0, 0};
        dir_tab[5]  = '{'{32'hFFFFFFFF, 32'hFFFFFFFF, -32'sh80000000, -32'sh80000000,
                          32'hFFFFFFFF, 32'hFFFFFFFF, -32'sh80000000, 32'sh7FFFFFFF},
                        0, 0, 0, 0};
        dir_tab[6]  = '{'{32'h1, 32'h1, -32'sh80000000, 32'sh7FFFFFFF, 32'h0, 32'h0,
                          32'sh0, 32'sh0}, 0, 0, 0, 0};
        dir_tab[7]  = '{'{32'h10000, 32'h10000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'hFFFFFFFF,
                          32'h0, 32'sh7FFFFFFF, -32'sh80000000}, 0, 0, 0, 0};
        dir_tab[8]  = '{'{32'h1, 32'h4, 32'sh0, 32'sh0, 32'h0, 32'hFFFFFFFF,
                          32'sh0, 32'sh0}, 0, 0, 0, 0};
        dir_tab[9]  = '{'{32'h1, 32'h4, 32'sh10000, 32'sh0, 32'h10000, 32'h10000,
                          32'sh20000, -32'sh20000}, 0, 0, 0, 0};
        dir_tab[10] = '{'{32'h8000, 32'h8000, -32'sh7FFFFFFF, -32'sh1, 32'h80000000,
                          32'h80000000, -32'sh1, 32'sh1}, 0, 0, 0, 0};
        dir_tab[11] = '{'{32'h20000, 32'h8, 32'sh7FFFFFFF, 32'sh1, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 32'sh1, -32'sh1}, 0, 0, 0, 0};
        dir_tab[12] = '{'{32'hFFFF, 32'h10001, 32'sh55555555, -32'sh2AAAAAAB, 32'hAAAAAAAA,
                          32'h55555555, 32'sh55555555, -32'sh2AAAAAAB}, 0, 0, 0, 0};
        dir_tab[13] = '{'{32'h0, 32'h0, 32'sh0, 32'sh0, 32'h0, 32'h0,
                          32'sh7FFFFFFF, 32'sh7FFFFFFF}, 0, 0, 0, 0};
        dir_tab[14] = '{'{32'h0, 32'h0, 32'sh0, 32'sh0, 32'h0, 32'h0,
                          32'sh0, 32'sh0}, 0, 0, 0, 0};
        dir_tab[15] = '{'{32'h0, 32'h0, 32'sh0, 32'sh0, 32'h0, 32'h0,
                          32'sh1234, -32'sh4321}, 0, 0, 0, 0};

        for (int i = 0; i < LINE_DEPTH; i++) begin
            line_mass[i]  = 0;
            line_pres[i]  = 0;
            line_visc[i]  = 0;
            line_xarea[i] = 0;
        end
        {lc_mass, lc_pres, lc_visc, lc_yarea} = '0;
        {lp_mass, lp_pres, lp_visc} = '0;
        col_cnt = 0;
        row_cnt = 0;
        row_len_reg = snvu_pkg::ROW_LENGTH_RESET;
        dt_reg = snvu_pkg::TIME_STEP_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // part of row 0 at the reset length fills line store entries
        // 0..FILL_CELLS-1; every later row length stays within them
        send_gap_pct = 15;
        stall_pct    = 53;
        repeat (FILL_CELLS) push_cell(rand_cell());
        drain();

        // directed: shortest rows (0 acts as 2), largest time step;
        // one filler word closes row 0 so the table starts at col 0 row 1
        write_reg(snvu_pkg::REG_ROW_LENGTH, 32'd0);
        write_reg(snvu_pkg::REG_TIME_STEP, 32'hFFFFFFFF);
        push_cell(rand_cell());
        foreach (dir_tab[i]) begin
            send_cell(dir_tab[i].c, has, r);
            if (has && dir_tab[i].typed) begin
                r.vx   = dir_tab[i].vx;
                r.vy   = dir_tab[i].vy;
                r.zero = dir_tab[i].zero;
            end
            if (has) node_q.push_back(r);
        end
        drain();

        // random phases: receiver idles, then sender idles, then neither
        random_phase(32'd150, snvu_pkg::TIME_STEP_RESET, 15, 53, 200);
        random_phase(32'd3, 32'd0, 53, 15, 150);
        random_phase(32'd5, $urandom, 53, 15, 100);
        random_phase(32'd17, $urandom, 0, 0, 200);

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
